### src/pmc_pkg.sv
// Shared types, register indexes and helper functions for the pixel mask and crop core.
`default_nettype none
package pmc_pkg;

   // Register indexes on the configuration channel.
   typedef enum logic [3:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1,
      REG_CROP_ORIGIN  = 4'd2,
      REG_CROP_SIZE    = 4'd3,
      REG_MASK_A       = 4'd4,
      REG_MASK_B       = 4'd5,
      REG_MASK_C       = 4'd6,
      REG_MASK_D       = 4'd7
   } reg_index_type;

   localparam int CoordBits   = 12;
   localparam int RectBits    = 64;
   localparam int PixelBits   = 24;
   localparam int MaxSlots    = 4;
   localparam logic [7:0] ByteMax = 8'hFF;

   localparam logic [CoordBits-1:0] FrameWidthReset  = 12'd640;
   localparam logic [CoordBits-1:0] FrameHeightReset = 12'd480;

   // Signed coordinate wide enough for a 16-bit field plus a 16-bit field.
   typedef logic signed [17:0] coord_type;
   typedef logic [CoordBits-1:0] count_type;

   // Sign-extend a 16-bit register field.
   function automatic coord_type sext16(input logic [15:0] v);
      return coord_type'({{2{v[15]}}, v});
   endfunction

   // Zero-extend a 12-bit count.
   function automatic coord_type zext12(input count_type v);
      return coord_type'({6'd0, v});
   endfunction

   function automatic coord_type max0(input coord_type a);
      return (a > 0) ? a : coord_type'(0);
   endfunction

   function automatic coord_type min2(input coord_type a, input coord_type b);
      return (a < b) ? a : b;
   endfunction

   // True when the pixel at col/row lies in the rectangle clipped to the frame.
   function automatic logic mask_hit(input logic [RectBits-1:0] rect,
                                     input count_type col, input count_type row,
                                     input count_type fw, input count_type fh);
      coord_type mx, my, mw, mh, x0, y0, x1, y1, c, r;
      mx = sext16(rect[15:0]);
      my = sext16(rect[31:16]);
      mw = sext16(rect[47:32]);
      mh = sext16(rect[63:48]);
      x0 = max0(mx);
      y0 = max0(my);
      x1 = min2(zext12(fw), mx + mw);
      y1 = min2(zext12(fh), my + mh);
      c  = zext12(col);
      r  = zext12(row);
      return (mw > 0) && (mh > 0) && (c >= x0) && (c < x1) && (r >= y0) && (r < y1);
   endfunction

endpackage
`default_nettype wire

### src/pixel_mask_and_crop_core.sv
// Top level of the pixel mask and crop core: position counters, mask and crop logic.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tdata: pixel_in; tuser: frame_start
//  rsp      out        rsp_tvalid/rsp_tready  tdata: pixel_out; tlast: last_pixel
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One pixel is accepted per cycle while rsp does not stall; a pixel reaches the output
// through one input stage register and one result register.
// Pixels outside the crop window are dropped in the second stage and give no beat.
// Reset clears the position counters and valid bits, and resets the config registers.
// A stall on rsp holds the result register and backs up into the input stage.
// The configuration channel is always ready.
`default_nettype none
module pixel_mask_and_crop_core #(
   parameter int CHANNELS   = 3,
   parameter int MASK_SLOTS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input pixel stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] pixel_in
   input  wire logic        req_tuser,   // [0] frame_start
   // Result pixel stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [23:0] pixel_out
   output logic             rsp_tlast,   // last_pixel
   // Register writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import pmc_pkg::*;

   localparam int PixBits = 8 * CHANNELS;
   localparam logic [PixBits-1:0] PixWhite = {CHANNELS{ByteMax}};

   // Configuration registers.
   count_type                  frame_width_ff, frame_height_ff;
   logic [31:0]                crop_origin_ff, crop_size_ff;
   logic [RectBits-1:0]        mask_ff [MASK_SLOTS];

   // Position counters.
   count_type                  column_ff, column_in, row_ff, row_in;
   count_type                  cur_col, cur_row;
   logic [CoordBits:0]         col_plus, row_plus;

   // Input stage.
   logic                       s1_valid_ff;
   logic [PixBits-1:0]         s1_pixel_ff;
   count_type                  s1_col_ff, s1_row_ff;

   // Result stage.
   logic                       rsp_valid_ff;
   logic [PixelBits-1:0]       rsp_pixel_ff;
   logic                       rsp_last_ff;

   logic                       req_fire, rsp_advance;
   logic                       masked, emit, last;
   logic [PixBits-1:0]         pixel_res;
   coord_type                  cxr, cyr, cwr, chr, cx, cy, cw, ch, col_s, row_s;

   assign csr_ready   = 1'b1;
   assign rsp_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || rsp_advance;
   assign req_fire    = req_tvalid && req_tready;

   // Register write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FrameWidthReset;
         frame_height_ff <= FrameHeightReset;
         crop_origin_ff  <= '0;
         crop_size_ff    <= '0;
         for (int i = 0; i < MASK_SLOTS; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[CoordBits-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[CoordBits-1:0];
            REG_CROP_ORIGIN:  crop_origin_ff  <= csr_data[31:0];
            REG_CROP_SIZE:    crop_size_ff    <= csr_data[31:0];
            REG_MASK_A, REG_MASK_B, REG_MASK_C, REG_MASK_D: begin
               for (int i = 0; i < MASK_SLOTS; i++) begin
                  if (csr_index == 4'(int'(REG_MASK_A) + i)) begin
                     mask_ff[i] <= csr_data;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Position of the incoming pixel and the counters' next values.
   always_comb begin
      cur_col   = req_tuser ? '0 : column_ff;
      cur_row   = req_tuser ? '0 : row_ff;
      col_plus  = {1'b0, cur_col} + 1'b1;
      row_plus  = {1'b0, cur_row} + 1'b1;
      column_in = column_ff;
      row_in    = row_ff;
      if (req_fire) begin
         if (col_plus >= {1'b0, frame_width_ff}) begin
            column_in = '0;
            row_in    = (row_plus >= {1'b0, frame_height_ff}) ? '0 : row_plus[CoordBits-1:0];
         end else begin
            column_in = col_plus[CoordBits-1:0];
            row_in    = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // Input stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_tdata[PixBits-1:0];
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
      end
   end

   // Mask test against every slot, crop window and last-pixel detection.
   always_comb begin
      masked = 1'b0;
      for (int i = 0; i < MASK_SLOTS; i++) begin
         masked = masked | mask_hit(mask_ff[i], s1_col_ff, s1_row_ff,
                                    frame_width_ff, frame_height_ff);
      end
      pixel_res = masked ? PixWhite : s1_pixel_ff;

      col_s = zext12(s1_col_ff);
      row_s = zext12(s1_row_ff);
      last  = ({1'b0, s1_col_ff} + 1'b1 == {1'b0, frame_width_ff}) &&
              ({1'b0, s1_row_ff} + 1'b1 == {1'b0, frame_height_ff});
      emit  = 1'b1;

      cxr = sext16(crop_origin_ff[15:0]);
      cyr = sext16(crop_origin_ff[31:16]);
      cwr = sext16(crop_size_ff[15:0]);
      chr = sext16(crop_size_ff[31:16]);
      cx  = max0(cxr);
      cy  = max0(cyr);
      cw  = min2(cwr, zext12(frame_width_ff) - cx);
      ch  = min2(chr, zext12(frame_height_ff) - cy);
      if ((cwr > 0) && (chr > 0) && (cw > 0) && (ch > 0)) begin
         emit = (col_s >= cx) && (col_s < cx + cw) && (row_s >= cy) && (row_s < cy + ch);
         last = (col_s + 1 == cx + cw) && (row_s + 1 == cy + ch);
      end
   end

   // Result register; pixels outside the window leave no beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_advance) begin
         rsp_valid_ff <= s1_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_advance && s1_valid_ff && emit) begin
         rsp_pixel_ff <= PixelBits'(pixel_res);
         rsp_last_ff  <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### tb/mask_crop_checker.sv
// Checker for the pixel mask and crop core: predicts every output beat and compares it.
`timescale 1ns / 100ps
module mask_crop_checker #(
   parameter int CHANNELS   = 3,
   parameter int MASK_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          errors,
   output int          pending
);
   import pmc_pkg::*;

   // Channel bytes at and above CHANNELS are always zero on the output.
   localparam logic [23:0] ChannelMask = 24'((64'd1 << (8 * CHANNELS)) - 64'd1);

   typedef struct packed {
      logic [23:0] pixel;
      logic        last;
   } out_pixel_type;

   out_pixel_type expected_pixels[$];

   // Shadow copy of the register file and of the raster position.
   logic [11:0] width_reg = FrameWidthReset;
   logic [11:0] height_reg = FrameHeightReset;
   logic [31:0] origin_reg = '0;
   logic [31:0] size_reg = '0;
   logic [63:0] rect_reg [MaxSlots];
   logic [11:0] col_cnt = '0;
   logic [11:0] row_cnt = '0;
   int          fail_count = 0;

   function automatic int field16(input logic [63:0] word, input int lsb);
      logic signed [15:0] f;
      f = word[lsb +: 16];
      return int'(f);
   endfunction

   // Works out whether the pixel at col/row leaves the block, and with what value.
   function automatic logic mask_and_window(input logic [23:0] pix, input int col,
                                            input int row, output out_pixel_type res);
      int   fw, fh, mx, my, mw, mh, x0, y0, x1, y1, cx, cy, cw, ch, slot;
      logic hit, emit, last;
      fw   = int'(width_reg);
      fh   = int'(height_reg);
      hit  = 1'b0;
      emit = 1'b1;
      for (slot = 0; slot < MASK_SLOTS && slot < MaxSlots; slot++) begin
         mx = field16(rect_reg[slot], 0);
         my = field16(rect_reg[slot], 16);
         mw = field16(rect_reg[slot], 32);
         mh = field16(rect_reg[slot], 48);
         if (mw > 0 && mh > 0) begin
            x0 = (mx > 0) ? mx : 0;
            y0 = (my > 0) ? my : 0;
            x1 = (mx + mw < fw) ? mx + mw : fw;
            y1 = (my + mh < fh) ? my + mh : fh;
            if (col >= x0 && col < x1 && row >= y0 && row < y1) hit = 1'b1;
         end
      end
      last = (col == fw - 1) && (row == fh - 1);
      // Crop applies only when the requested window survives clamping to the frame.
      cw = field16({32'd0, size_reg}, 0);
      ch = field16({32'd0, size_reg}, 16);
      if (cw > 0 && ch > 0) begin
         cx = field16({32'd0, origin_reg}, 0);
         cy = field16({32'd0, origin_reg}, 16);
         cx = (cx > 0) ? cx : 0;
         cy = (cy > 0) ? cy : 0;
         cw = (cw < fw - cx) ? cw : fw - cx;
         ch = (ch < fh - cy) ? ch : fh - cy;
         if (cw > 0 && ch > 0) begin
            emit = col >= cx && col < cx + cw && row >= cy && row < cy + ch;
            last = (col == cx + cw - 1) && (row == cy + ch - 1);
         end
      end
      res.pixel = hit ? ChannelMask : (pix & ChannelMask);
      res.last  = last;
      return emit;
   endfunction

   always @(posedge clock) begin : watch
      out_pixel_type want;
      out_pixel_type next;
      if (reset) begin
         width_reg  = FrameWidthReset;
         height_reg = FrameHeightReset;
         origin_reg = '0;
         size_reg   = '0;
         foreach (rect_reg[i]) rect_reg[i] = '0;
         col_cnt = '0;
         row_cnt = '0;
         expected_pixels.delete();
      end else begin
         // Register writes; unknown indexes are dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_reg  = csr_data[11:0];
               REG_FRAME_HEIGHT: height_reg = csr_data[11:0];
               REG_CROP_ORIGIN:  origin_reg = csr_data[31:0];
               REG_CROP_SIZE:    size_reg   = csr_data[31:0];
               REG_MASK_A, REG_MASK_B, REG_MASK_C, REG_MASK_D:
                  rect_reg[2'(csr_index - REG_MASK_A)] = csr_data;
               default: ;
            endcase
         end

         // Compare an output beat with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual pixel_out %06h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $display("%0t: pixel_out mismatch, expected %06h, actual %06h",
                           $time, want.pixel, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_pixel mismatch, expected %b, actual %b",
                           $time, want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end

         // Predict the input beat, then advance the raster position.
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               col_cnt = '0;
               row_cnt = '0;
            end
            if (mask_and_window(req_tdata, int'(col_cnt), int'(row_cnt), next))
               expected_pixels = {expected_pixels, next};
            if (int'(col_cnt) + 1 >= int'(width_reg)) begin
               col_cnt = '0;
               if (int'(row_cnt) + 1 >= int'(height_reg)) row_cnt = '0;
               else row_cnt = row_cnt + 12'd1;
            end else begin
               col_cnt = col_cnt + 12'd1;
            end
         end
      end
      errors  <= fail_count;
      pending <= expected_pixels.size();
   end

endmodule

### tb/tb.sv
// Testbench top for the pixel mask and crop core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import pmc_pkg::*;

   localparam int Channels  = 3;
   localparam int Slots     = 4;
   localparam int ItemGoal  = 1300;
   localparam int Settle    = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          errors;
   int          pending;

   // Stimulus bookkeeping: frame shape last written, and pixels sent so far.
   bit          steady = 1'b0;
   int          stall_left = 0;
   int          frame_w = 640;
   int          frame_h = 480;
   int          sent = 0;

   pixel_mask_and_crop_core #(.CHANNELS(Channels), .MASK_SLOTS(Slots)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mask_crop_checker #(.CHANNELS(Channels), .MASK_SLOTS(Slots)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Two signed 16-bit coordinates packed x low, y high.
   function automatic logic [31:0] pair(input int x, input int y);
      return {16'(y), 16'(x)};
   endfunction

   function automatic logic [63:0] rect(input int x, input int y, input int w, input int h);
      return {pair(w, h), pair(x, y)};
   endfunction

   // Random mask rectangle, mostly near the frame, sometimes disabled or arbitrary.
   function automatic logic [63:0] pick_rect(input int fw, input int fh);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return {$urandom, $urandom};
      if (r == 2) return rect(0, 0, int'($urandom_range(0, 3)) - 3, $urandom_range(1, 4));
      if (r == 3) return rect(-32768, int'($urandom_range(0, 3)) - 1, 32767, 32767);
      return rect(int'($urandom_range(0, fw + 3)) - 3, int'($urandom_range(0, fh + 3)) - 3,
                  $urandom_range(1, fw + 2), $urandom_range(1, fh + 2));
   endfunction

   // Result side: ready with random stalls, or always ready in a steady stretch.
   always @(posedge clock) begin
      if (steady || stall_left == 0) begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end else begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Loads every register; unused upper bits carry junk that the block must drop.
   task automatic load_setup(input int fw, input int fh, input logic [31:0] origin,
                             input logic [31:0] size, input logic [63:0] ma,
                             input logic [63:0] mb, input logic [63:0] mc,
                             input logic [63:0] md);
      logic [63:0] junk;
      if ($urandom_range(0, 2) == 0)
         write_reg(4'(int'(REG_MASK_D) + $urandom_range(1, 8)), {$urandom, $urandom});
      junk = {$urandom, $urandom};
      junk[11:0] = 12'(fw);
      write_reg(REG_FRAME_WIDTH, junk);
      junk = {$urandom, $urandom};
      junk[11:0] = 12'(fh);
      write_reg(REG_FRAME_HEIGHT, junk);
      write_reg(REG_CROP_ORIGIN, {$urandom, origin});
      write_reg(REG_CROP_SIZE, {$urandom, size});
      write_reg(REG_MASK_A, ma);
      write_reg(REG_MASK_B, mb);
      write_reg(REG_MASK_C, mc);
      write_reg(REG_MASK_D, md);
      csr_valid <= 1'b0;
      frame_w = fw;
      frame_h = fh;
   endtask

   task automatic send_pixel(input logic [23:0] pix, input logic fs);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold off until every predicted beat has come, then let dropped pixels clear.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (Settle) @(posedge clock);
   endtask

   initial begin : stimulus
      int fw, fh, r, area, count, k;
      logic [31:0] origin, size;
      bit noise;
      logic fs;
      logic [23:0] pix;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setup: full 640x480 frame, no mask, no crop.
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h555555, 1'b0);
      send_pixel(24'hAAAAAA, 1'b0);
      drain();

      // Single-pixel frame: every pixel is masked and is the last one.
      load_setup(1, 1, '0, '0, rect(0, 0, 1, 1), '0, '0, '0);
      send_pixel(24'h123456, 1'b1);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFEDCBA, 1'b1);
      drain();

      // Largest frame: clipped mask at a negative origin, zero-width and
      // negative-height masks, and a crop window clamped at the top left.
      load_setup(4095, 4095, pair(-3, -3), pair(5, 5), rect(-5, -5, 7, 6),
                 rect(0, 0, 0, 5), rect(0, 0, 3, -1), rect(3, 0, 1, 1));
      for (k = 0; k < 6; k++) send_pixel(24'($urandom), k == 0);
      drain();

      // Crop window beyond the frame is ignored; a mask ending left of the frame
      // hits nothing, and a mask running off the far corner is clipped.
      load_setup(4, 3, pair(5, 0), pair(2, 2), rect(-32768, -32768, 32767, 32767),
                 rect(1, 1, 32767, 32767), rect(2, 0, -32768, 4), '0);
      for (k = 0; k < 12; k++) send_pixel(24'($urandom), k == 0);
      drain();

      // Random setups, each followed by whole frames or the start of a large one.
      while (sent < ItemGoal) begin
         r  = $urandom_range(0, 19);
         fw = (r == 0) ? 1 : (r == 1) ? 4095 : $urandom_range(2, 12);
         r  = $urandom_range(0, 19);
         fh = (r == 0) ? 1 : (r == 1) ? 4095 : $urandom_range(1, 8);
         r  = $urandom_range(0, 9);
         if (r == 0) begin
            origin = '0;
            size   = '0;
         end else if (r == 1) begin
            origin = $urandom;
            size   = $urandom;
         end else if (r == 2) begin
            origin = pair(-32768, -32768);
            size   = pair(32767, 32767);
         end else if (r == 3) begin
            origin = pair($urandom_range(0, 4), $urandom_range(0, 4));
            size   = pair(int'($urandom_range(0, 2)) - 2, $urandom_range(1, 4));
         end else begin
            origin = pair(int'($urandom_range(0, fw + 4)) - 3,
                          int'($urandom_range(0, fh + 4)) - 3);
            size   = pair($urandom_range(1, fw + 3), $urandom_range(1, fh + 3));
         end
         load_setup(fw, fh, origin, size, pick_rect(fw, fh), pick_rect(fw, fh),
                    pick_rect(fw, fh), pick_rect(fw, fh));

         steady = ($urandom_range(0, 4) == 0);
         noise  = ($urandom_range(0, 5) == 0);
         area   = frame_w * frame_h;
         count  = (area <= 120) ? area * $urandom_range(1, 3) : $urandom_range(10, 40);
         for (k = 0; k < count; k++) begin
            if (noise) fs = ($urandom_range(0, 9) == 0);
            else if (area <= 120) fs = (k % area == 0);
            else fs = (k == 0);
            r   = $urandom_range(0, 9);
            pix = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF : 24'($urandom);
            send_pixel(pix, fs);
         end
         drain();
         steady = 1'b0;
      end

      if (errors == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

### files.f
src/pmc_pkg.sv
src/pixel_mask_and_crop_core.sv
tb/mask_crop_checker.sv
tb/tb.sv
